[design/bfpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// shared types and constants of the best-fit partition allocator
// ----------------------------------------------------------------------------
package bfpa_pkg;

	// fixed field widths at the block's ports
	localparam int IN_IDX_W   = 3;
	localparam int OUT_SIZE_W = 16;
	localparam int CFG_W      = 4;

	// reset value of the partitions-in-use register
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_COMMIT
	} bfpa_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic scan_en;
		logic load_commit;
		logic alloc_commit;
	} bfpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_busy;
	} bfpa_status_t;

endpackage

[design/best_fit_partition_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_unit
// best-fit allocator over a table of per-partition free sizes
// ----------------------------------------------------------------------------
// sequence: a load is captured while idle, written to the table ram in the load
//   state if its index is in range, then placed in the result register; an
//   allocate is captured, scans the table ram one entry per cycle over N
//   partitions (min of partitions_in_use and PARTITIONS), compares the last read,
//   leaves the scan, commits to the table and is placed in the result register
// a new command is taken only once the controller is back in idle (busy low)
// done is high for one cycle per result; the receiver cannot stall
// reset: asynchronous, active low; free sizes read as zero, partitions_in_use 8
// ----------------------------------------------------------------------------
module best_fit_partition_allocator_unit #(
	parameter int PARTITIONS = 8,
	parameter int SIZE_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command side: transfer when start is high and busy is low
	input  logic                           start,
	output logic                           busy,
	input  logic                           cmd,
	input  logic [bfpa_pkg::IN_IDX_W-1:0]   load_index,
	input  logic [bfpa_pkg::OUT_SIZE_W-1:0] load_size,
	input  logic [bfpa_pkg::OUT_SIZE_W-1:0] request_size,
	// result side: one transfer per cycle of done
	output logic                           done,
	output logic                           granted,
	output logic [bfpa_pkg::IN_IDX_W-1:0]   chosen_partition,
	output logic [bfpa_pkg::OUT_SIZE_W-1:0] size_before,
	output logic [bfpa_pkg::OUT_SIZE_W-1:0] size_after,
	// partitions_in_use register, to be written only while idle; the block does not enforce it
	input  logic                           cfg_wr_en,
	input  logic [bfpa_pkg::CFG_W-1:0]      cfg_wr_data
);

	import bfpa_pkg::*;

	// command and status between controller and datapath
	bfpa_cmd_t    ctl;
	bfpa_status_t status;

	// controller: idle, load write-back, table scan, allocate commit
	bfpa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.status(status),
		.ctl   (ctl),
		.busy  (busy)
	);

	// datapath: table ram with valid bits, running best-fit compare,
	// registered result outputs
	bfpa_dp #(
		.PARTITIONS(PARTITIONS),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.status          (status),
		.load_index      (load_index),
		.load_size       (load_size),
		.request_size    (request_size),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.done            (done),
		.granted         (granted),
		.chosen_partition(chosen_partition),
		.size_before     (size_before),
		.size_after      (size_after)
	);

endmodule

[design/bfpa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bfpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/bfpa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_ctrl
// controller state machine: sequences load, scan and commit
// ----------------------------------------------------------------------------
module bfpa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  cmd,
	input  bfpa_pkg::bfpa_status_t status,
	output bfpa_pkg::bfpa_cmd_t    ctl,
	output logic                  busy
);

	import bfpa_pkg::*;

	bfpa_state_t state_q;
	bfpa_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = (cmd == CMD_ALLOC) ? ST_SCAN : ST_LOAD;
				end
			end
			ST_LOAD:   state_nxt = ST_IDLE;
			ST_SCAN: begin
				if (!status.scan_busy) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			ST_LOAD:   ctl.load_commit  = 1'b1;
			ST_SCAN:   ctl.scan_en      = 1'b1;
			ST_COMMIT: ctl.alloc_commit = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

endmodule

[design/bfpa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_dp
// datapath: item registers, free-size table, best-fit scan, result registers
// ----------------------------------------------------------------------------
module bfpa_dp #(
	parameter int PARTITIONS = 8,
	parameter int SIZE_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bfpa_pkg::bfpa_cmd_t                 ctl,
	output bfpa_pkg::bfpa_status_t              status,
	input  logic [bfpa_pkg::IN_IDX_W-1:0]       load_index,
	input  logic [bfpa_pkg::OUT_SIZE_W-1:0]     load_size,
	input  logic [bfpa_pkg::OUT_SIZE_W-1:0]     request_size,
	input  logic                               cfg_wr_en,
	input  logic [bfpa_pkg::CFG_W-1:0]          cfg_wr_data,
	output logic                               done,
	output logic                               granted,
	output logic [bfpa_pkg::IN_IDX_W-1:0]       chosen_partition,
	output logic [bfpa_pkg::OUT_SIZE_W-1:0]     size_before,
	output logic [bfpa_pkg::OUT_SIZE_W-1:0]     size_after
);

	import bfpa_pkg::*;

	localparam int AW = $clog2(PARTITIONS);
	localparam int XW = (AW > IN_IDX_W) ? AW : IN_IDX_W;
	localparam int CW = $clog2(PARTITIONS + 1);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;

	// configuration
	logic [CFG_W-1:0] cfg_q;

	// captured item
	logic [IN_IDX_W-1:0]  load_index_q;
	logic [SIZE_BITS-1:0] load_size_q;
	logic [SIZE_BITS-1:0] req_q;

	// scan state
	logic [CW-1:0]        idx_q;
	logic                 rd_valid_s1;
	logic [AW-1:0]        idx_s1;
	logic                 vld_s1;
	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;

	// entry valid bits, an unwritten entry reads as zero
	logic [PARTITIONS-1:0] valid_q;

	logic [LW-1:0]        cfg_ext;
	logic [LW-1:0]        part_lw;
	logic [LW-1:0]        limit;
	logic                 issue_more;
	logic [XW-1:0]        ld_ext;
	logic                 ld_in_range;
	logic [AW-1:0]        ld_addr;
	logic [AW-1:0]        rd_addr;
	logic                 rd_en;
	logic [SIZE_BITS-1:0] rd_data;
	logic [SIZE_BITS-1:0] s_eff;
	logic                 better;
	logic [SIZE_BITS-1:0] remain;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [SIZE_BITS-1:0] wr_data;

	always_comb begin
		cfg_ext     = LW'(cfg_q);
		part_lw     = LW'(PARTITIONS);
		limit       = (cfg_ext > part_lw) ? part_lw : cfg_ext;
		issue_more  = LW'(idx_q) < limit;
		ld_ext      = XW'(load_index_q);
		ld_in_range = {1'b0, ld_ext} < (XW + 1)'(PARTITIONS);
		ld_addr     = ld_ext[AW-1:0];
		rd_addr     = idx_q[AW-1:0];
		rd_en       = ctl.scan_en && issue_more;
		s_eff       = vld_s1 ? rd_data : '0;
		better      = (s_eff >= req_q) && (!found_q || (s_eff < best_size_q));
		remain      = best_size_q - req_q;
		wr_en       = (ctl.load_commit && ld_in_range) || (ctl.alloc_commit && found_q);
		wr_addr     = ctl.load_commit ? ld_addr : best_idx_q;
		wr_data     = ctl.load_commit ? load_size_q : remain;
	end

	assign status.scan_busy = issue_more || rd_valid_s1;

	bfpa_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(PARTITIONS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			load_index_q <= load_index;
			load_size_q  <= SIZE_BITS'(load_size);
			req_q        <= SIZE_BITS'(request_size);
		end
	end

	// scan control, read data is registered and follows its address in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else if (ctl.capture) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else if (ctl.scan_en) begin
			if (issue_more) begin
				idx_q <= idx_q + 1'b1;
			end
			rd_valid_s1 <= issue_more;
			if (rd_valid_s1 && better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_addr;
			vld_s1 <= valid_q[rd_addr];
		end
		if (ctl.scan_en && rd_valid_s1 && better) begin
			best_idx_q  <= idx_s1;
			best_size_q <= s_eff;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.load_commit || ctl.alloc_commit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_commit) begin
			granted          <= 1'b0;
			chosen_partition <= load_index_q;
			size_before      <= '0;
			size_after       <= ld_in_range ? OUT_SIZE_W'(load_size_q) : '0;
		end else if (ctl.alloc_commit) begin
			granted          <= found_q;
			chosen_partition <= found_q ? IN_IDX_W'(best_idx_q) : '0;
			size_before      <= found_q ? OUT_SIZE_W'(best_size_q) : '0;
			size_after       <= found_q ? OUT_SIZE_W'(remain) : '0;
		end
	end

endmodule
